### hw/rtl/lhm_pkg.sv
// shared constants and types for the latency histogram monitor
`timescale 1ns / 1ps
package lhm_pkg;

   localparam int PERIOD_W   = 32;
   localparam int INDEX_W    = 31;
   localparam int COUNT_W    = 32;
   localparam int SUM_W      = 64;
   localparam int HIT_W      = 3;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 32;

   localparam int LHM_BUCKETS = 8;

   // serial datapath: two bits of sum and compare per cycle
   localparam int DIGIT_W    = 2;
   localparam int SERIAL_STEPS = SUM_W / DIGIT_W;
   localparam int PER_DIGITS = PERIOD_W / DIGIT_W;
   localparam int STEP_W     = $clog2(SERIAL_STEPS);
   localparam int BW_W       = $clog2(PERIOD_W + 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_PERIOD = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_BUCKET_WIDTH  = CSR_ADDR_W'(1);

   localparam logic [PERIOD_W-1:0] TARGET_RESET = PERIOD_W'(1000000);
   localparam logic [PERIOD_W-1:0] WIDTH_RESET  = PERIOD_W'(100000);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic add_en;
      logic commit;
   } stats_ctrl_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
      logic [PERIOD_W-1:0] min;
      logic [PERIOD_W-1:0] max;
      logic [INDEX_W-1:0]  min_idx;
      logic [INDEX_W-1:0]  max_idx;
   } stats_type;

endpackage

### hw/rtl/lhm_channels.sv
// channel interfaces: request, response and register write
`timescale 1ns / 1ps
interface lhm_req_if;
   logic                          valid;
   logic                          ready;
   logic [lhm_pkg::PERIOD_W-1:0]  period_ns;
   logic [lhm_pkg::INDEX_W-1:0]   sample_index;

   modport source (output valid, output period_ns, output sample_index, input ready);
   modport sink   (input valid, input period_ns, input sample_index, output ready);
endinterface

interface lhm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lhm_pkg::HIT_W-1:0]     hit_bucket;
   logic [lhm_pkg::COUNT_W-1:0]   bucket_total;
   logic [lhm_pkg::COUNT_W-1:0]   sample_count;
   logic [lhm_pkg::SUM_W-1:0]     period_sum;
   logic [lhm_pkg::PERIOD_W-1:0]  period_min;
   logic [lhm_pkg::PERIOD_W-1:0]  period_max;
   logic [lhm_pkg::INDEX_W-1:0]   min_at_index;
   logic [lhm_pkg::INDEX_W-1:0]   max_at_index;

   modport source (output valid, output hit_bucket, output bucket_total,
                   output sample_count, output period_sum, output period_min,
                   output period_max, output min_at_index, output max_at_index,
                   input ready);
   modport sink   (input valid, input hit_bucket, input bucket_total,
                   input sample_count, input period_sum, input period_min,
                   input period_max, input min_at_index, input max_at_index,
                   output ready);
endinterface

interface lhm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lhm_pkg::CSR_ADDR_W-1:0]  index;
   logic [lhm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/lhm_divider.sv
// bit-serial restoring divider that yields the histogram bucket of the lateness
`timescale 1ns / 1ps
module lhm_divider #(
   parameter int BUCKETS = lhm_pkg::LHM_BUCKETS
) (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          step,
   input  logic [lhm_pkg::STEP_W-1:0]    step_idx,
   input  logic [lhm_pkg::PERIOD_W-1:0]  period,
   input  logic [lhm_pkg::PERIOD_W-1:0]  target,
   input  logic [lhm_pkg::PERIOD_W-1:0]  divisor,
   output logic [$clog2(BUCKETS)-1:0]    bucket
);
   import lhm_pkg::*;

   localparam int IDX_W = $clog2(BUCKETS);
   localparam int LAST  = BUCKETS - 1;

   logic [PERIOD_W-1:0] dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [BW_W-1:0]     bw_ff, bw_in;
   logic [PERIOD_W-1:0] late;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W:0]   diff;
   logic                ge;

   always_comb begin
      late    = (period >= target) ? (period - target) : '0;
      shifted = {rem_ff, dvd_ff[PERIOD_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = (shifted >= {1'b0, divisor});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      bw_in   = bw_ff;
      if (start) begin
         dvd_in = late;
         rem_in = '0;
         bw_in  = '0;
      end else if (step) begin
         dvd_in = {dvd_ff[PERIOD_W-2:0], 1'b0};
         rem_in = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
         // first quotient one seen fixes the bit width
         if (ge && (bw_ff == '0)) begin
            bw_in = BW_W'(PERIOD_W) - BW_W'(step_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      bw_ff  <= bw_in;
   end

   assign bucket = (bw_ff < BW_W'(LAST)) ? IDX_W'(bw_ff) : IDX_W'(LAST);

endmodule

### hw/rtl/lhm_stats.sv
// running count, sum, minimum and maximum with digit-serial add and compare
`timescale 1ns / 1ps
module lhm_stats (
   input  logic                          clock,
   input  logic                          reset,
   input  lhm_pkg::stats_ctrl_type       ctrl,
   input  logic [lhm_pkg::PERIOD_W-1:0]  period,
   input  logic [lhm_pkg::INDEX_W-1:0]   index,
   output lhm_pkg::stats_type            result
);
   import lhm_pkg::*;

   logic [PERIOD_W-1:0] per_ff, per_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                carry_ff, carry_in;
   logic                lt_ff, lt_in;
   logic                gt_ff, gt_in;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PERIOD_W-1:0] min_ff, min_in;
   logic [PERIOD_W-1:0] max_ff, max_in;
   logic [INDEX_W-1:0]  min_idx_ff, min_idx_in;
   logic [INDEX_W-1:0]  max_idx_ff, max_idx_in;

   logic [DIGIT_W-1:0]  p_dig;
   logic [DIGIT_W-1:0]  add_dig;
   logic [DIGIT_W:0]    dsum;
   stats_type           nx;

   always_comb begin
      p_dig   = per_ff[DIGIT_W-1:0];
      add_dig = ctrl.add_en ? p_dig : '0;
      dsum    = {1'b0, sum_ff[DIGIT_W-1:0]} + {1'b0, add_dig} + {{DIGIT_W{1'b0}}, carry_ff};

      // values after this item, valid once all digits have passed
      nx.count   = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);
      nx.sum     = carry_ff ? '1 : sum_ff;
      nx.min     = lt_ff ? per_ff : min_ff;
      nx.min_idx = lt_ff ? idx_ff : min_idx_ff;
      nx.max     = gt_ff ? per_ff : max_ff;
      nx.max_idx = gt_ff ? idx_ff : max_idx_ff;

      per_in     = per_ff;
      idx_in     = idx_ff;
      carry_in   = carry_ff;
      lt_in      = lt_ff;
      gt_in      = gt_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      min_idx_in = min_idx_ff;
      max_idx_in = max_idx_ff;

      if (ctrl.load) begin
         per_in   = period;
         idx_in   = index;
         carry_in = 1'b0;
         lt_in    = 1'b0;
         gt_in    = 1'b0;
      end else if (ctrl.step) begin
         // lsb-first rotation; the most significant differing digit decides
         per_in   = {p_dig, per_ff[PERIOD_W-1:DIGIT_W]};
         min_in   = {min_ff[DIGIT_W-1:0], min_ff[PERIOD_W-1:DIGIT_W]};
         max_in   = {max_ff[DIGIT_W-1:0], max_ff[PERIOD_W-1:DIGIT_W]};
         sum_in   = {dsum[DIGIT_W-1:0], sum_ff[SUM_W-1:DIGIT_W]};
         carry_in = dsum[DIGIT_W];
         if (p_dig != min_ff[DIGIT_W-1:0]) begin
            lt_in = (p_dig < min_ff[DIGIT_W-1:0]);
         end
         if (p_dig != max_ff[DIGIT_W-1:0]) begin
            gt_in = (p_dig > max_ff[DIGIT_W-1:0]);
         end
      end else if (ctrl.commit) begin
         count_in   = nx.count;
         sum_in     = nx.sum;
         min_in     = nx.min;
         min_idx_in = nx.min_idx;
         max_in     = nx.max;
         max_idx_in = nx.max_idx;
      end
   end

   always_ff @(posedge clock) begin
      per_ff   <= per_in;
      idx_ff   <= idx_in;
      carry_ff <= carry_in;
      lt_ff    <= lt_in;
      gt_ff    <= gt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_ff     <= '0;
         min_ff     <= '1;
         max_ff     <= '0;
         min_idx_ff <= '0;
         max_idx_ff <= '0;
      end else begin
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         min_idx_ff <= min_idx_in;
         max_idx_ff <= max_idx_in;
      end
   end

   assign result = nx;

endmodule

### hw/rtl/latency_histogram_monitor.sv
// latency histogram monitor: item control, bucket counters and result register
// a request is loaded in idle, stepped through the run state and committed from
// the finish state, which waits while the output register still holds a result;
// the 32-step bit-serial divider paces the 2-bit serial sum and min/max compare
// requests are taken only in idle, also while a result waits in the output register
// synchronous reset clears statistics, counters, state and valid; csrs get defaults
`timescale 1ns / 1ps
module latency_histogram_monitor #(
   parameter int BUCKETS = lhm_pkg::LHM_BUCKETS
) (
   input  logic       clock,
   input  logic       reset,
   lhm_req_if.sink    req_bus,
   lhm_rsp_if.source  rsp_bus,
   lhm_csr_if.sink    csr_bus
);
   import lhm_pkg::*;

   localparam int IDX_W = $clog2(BUCKETS);

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [PERIOD_W-1:0]  target_ff, target_in;
   logic [PERIOD_W-1:0]  width_ff, width_in;
   logic [COUNT_W-1:0]   counts_ff [BUCKETS];
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [HIT_W-1:0]     hit_ff;
   logic [COUNT_W-1:0]   total_ff;
   stats_type            out_ff;

   stats_ctrl_type       ctrl;
   stats_type            stats_nx;
   logic [IDX_W-1:0]     bucket;
   logic [COUNT_W-1:0]   total_nx;
   logic                 req_xfer;

   assign req_xfer = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      req_bus.ready  = 1'b0;
      ctrl           = '0;
      ctrl.add_en    = (step_ff < STEP_W'(PER_DIGITS));
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               ctrl.load = 1'b1;
               step_in   = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == '1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               ctrl.commit  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      target_in = target_ff;
      width_in  = width_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_TARGET_PERIOD: target_in = csr_bus.data;
            CSR_BUCKET_WIDTH:  width_in  = csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   assign total_nx = (counts_ff[bucket] == '1) ? counts_ff[bucket]
                                                : counts_ff[bucket] + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         target_ff    <= TARGET_RESET;
         width_ff     <= WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         target_ff    <= target_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.commit) begin
            counts_ff[bucket] <= total_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         hit_ff   <= HIT_W'(bucket);
         total_ff <= total_nx;
         out_ff   <= stats_nx;
      end
   end

   lhm_divider #(
      .BUCKETS (BUCKETS)
   ) u_divider (
      .clock    (clock),
      .start    (req_xfer),
      .step     (ctrl.step),
      .step_idx (step_ff),
      .period   (req_bus.period_ns),
      .target   (target_ff),
      .divisor  (width_ff),
      .bucket   (bucket)
   );

   lhm_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .period (req_bus.period_ns),
      .index  (req_bus.sample_index),
      .result (stats_nx)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit_bucket   = hit_ff;
   assign rsp_bus.bucket_total = total_ff;
   assign rsp_bus.sample_count = out_ff.count;
   assign rsp_bus.period_sum   = out_ff.sum;
   assign rsp_bus.period_min   = out_ff.min;
   assign rsp_bus.period_max   = out_ff.max;
   assign rsp_bus.min_at_index = out_ff.min_idx;
   assign rsp_bus.max_at_index = out_ff.max_idx;

endmodule
